>>> hw/rtl/hlc_pkg.sv
// shared types, constants and helpers for the hashed lru name cache core
// depends on nothing; imported by every module of the block
package hlc_pkg;

    localparam int CACHE_ENTRIES = 256;
    localparam int NAME_BYTES    = 16;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int LEN_W         = 5;
    localparam int COUNT_W       = 9;
    localparam int HANDLE_W      = 32;
    localparam int NAME_W        = 64;

    typedef enum logic [2:0] {
        OP_ENTER      = 3'd0,
        OP_LOOKUP     = 3'd1,
        OP_ZAP_PARENT = 3'd2,
        OP_ZAP_CHILD  = 3'd3,
        OP_ZAP_KEY    = 3'd4,
        OP_FLUSH      = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_MISS      = 3'd1,
        STAT_DISABLED  = 3'd2,
        STAT_TOO_LONG  = 3'd3,
        STAT_DUPLICATE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_SORT,
        FSM_INSERT,
        FSM_DONE
    } fsm_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_SORT,
        CELL_CLRHIT
    } cell_op_t;

    typedef struct packed {
        logic                valid;
        logic                hit;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] parent;
        logic [HANDLE_W-1:0] child;
        logic [NAME_W-1:0]   name_lo;
        logic [NAME_W-1:0]   name_hi;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
        logic     promote;
    } cell_ctl_t;

    typedef struct packed {
        logic key_hit;
        logic removed;
    } probe_t;

    // keeps name bytes 0..7 that lie below the length
    function automatic logic [NAME_W-1:0] mask_low(input logic [7:0] len);
        logic [NAME_W-1:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            m[8*k +: 8] = (len > 8'(k)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // keeps name bytes 8..15 that lie below the length
    function automatic logic [NAME_W-1:0] mask_high(input logic [7:0] len);
        logic [NAME_W-1:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            m[8*k +: 8] = (len > 8'(k + 8)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/hashed_lru_name_cache_core.sv
// top level of the hashed lru name cache: request handshake, sequencer and cell row
// depends on hlc_pkg, hlc_cell and hlc_probe
//
// The cache keeps CACHE_ENTRIES entries in a row of cells ordered by recency, most
// recent in cell 0, with all invalid entries gathered at the least recent end, so
// the entry an enter replaces is always the last cell. One request is handled at a
// time. Every request that is not refused starts with a scan: the row rotates
// once through the probe at its end, which finds the key, flags the lookup hit or
// invalidates what a zap or flush removes. An enter that finds no duplicate then
// shifts the new entry in at the front; a lookup hit and a zap that removed
// something then go through odd-even neighbour sorting, which brings the hit to
// the front or packs the invalid entries to the back. A request refused as
// disabled, too long or an unused opcode goes straight to its result.
// Results are held in an output register until taken.
module hashed_lru_name_cache_core
    import hlc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: bit 0 is cache_enable
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // parent_handle[31:0], child_handle[63:32], target_handle[95:64],
    // name_low[159:96], name_high[223:160], name_length[231:224]
    input  logic [231:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_child[31:0], removed_count[40:32], evicted_valid[41], zero[47:42]
    output logic [47:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CACHE_ENTRIES - 1);

    // sequencer state
    fsm_t                fsm_reg, fsm_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                enable_reg;

    // latched request
    logic [2:0]          op_reg;
    logic [HANDLE_W-1:0] parent_reg, child_reg, target_reg;
    logic [NAME_W-1:0]   lo_reg, hi_reg;
    logic [LEN_W-1:0]    len_reg;

    // result being built
    logic                found_reg, found_next;
    logic [HANDLE_W-1:0] found_child_reg, found_child_next;
    logic [COUNT_W-1:0]  removed_reg, removed_next;
    logic                evicted_reg, evicted_next;
    status_t             status_reg, status_next;

    // output register
    logic                m_tvalid_reg;
    logic [47:0]         m_tdata_reg;
    logic [2:0]          m_tuser_reg;

    // row
    cell_ctl_t           ctl;
    entry_t              cell_q [CACHE_ENTRIES];
    entry_t              feed;
    entry_t              probe_feed;
    entry_t              new_entry;
    probe_t              probe_res;

    logic                s_accept;
    logic                in_len_long;
    logic [7:0]          in_len;
    logic                out_free;
    logic                hit_now;
    logic [COUNT_W-1:0]  removed_now;

    assign cfg_ready = 1'b1;
    assign s_tready  = (fsm_reg == FSM_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_len    = s_tdata[231:224];
    assign in_len_long = in_len > 8'(NAME_BYTES);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        new_entry         = '0;
        new_entry.valid   = 1'b1;
        new_entry.len     = len_reg;
        new_entry.parent  = parent_reg;
        new_entry.child   = child_reg;
        new_entry.name_lo = lo_reg;
        new_entry.name_hi = hi_reg;
    end

    // probe on the least recent end of the row, feeding back into cell 0
    hlc_probe u_probe (
        .op         (op_reg),
        .key_parent (parent_reg),
        .key_lo     (lo_reg),
        .key_hi     (hi_reg),
        .key_len    (len_reg),
        .target     (target_reg),
        .exit_entry (cell_q[CACHE_ENTRIES-1]),
        .feed       (probe_feed),
        .res        (probe_res)
    );

    assign feed = (fsm_reg == FSM_INSERT) ? new_entry : probe_feed;

    // row of cells; the ends pair with themselves so sorting leaves them alone
    for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
        hlc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .cell_odd (1'(i % 2)),
            .shift_in ((i == 0) ? feed : cell_q[(i == 0) ? 0 : i - 1]),
            .prev_in  (cell_q[(i == 0) ? 0 : i - 1]),
            .next_in  (cell_q[(i == CACHE_ENTRIES - 1) ? i : i + 1]),
            .q        (cell_q[i])
        );
    end

    // combined with this cycle's probe so the last scan step counts
    always_comb begin
        hit_now     = found_reg || probe_res.key_hit;
        removed_now = removed_reg;
        if (probe_res.removed && removed_reg != '1) begin
            removed_now = removed_reg + 1'b1;
        end
    end

    // next state and row control
    always_comb begin
        fsm_next         = fsm_reg;
        cnt_next         = cnt_reg;
        found_next       = found_reg;
        found_child_next = found_child_reg;
        removed_next     = removed_reg;
        evicted_next     = evicted_reg;
        status_next      = status_reg;
        ctl.op           = CELL_HOLD;
        ctl.phase        = cnt_reg[0];
        ctl.promote      = (op_reg == OP_LOOKUP);
        case (fsm_reg)
            FSM_IDLE: begin
                if (s_accept) begin
                    found_next       = 1'b0;
                    found_child_next = '0;
                    removed_next     = '0;
                    evicted_next     = 1'b0;
                    status_next      = STAT_OK;
                    cnt_next         = '0;
                    if (!enable_reg) begin
                        status_next = STAT_DISABLED;
                        fsm_next    = FSM_DONE;
                    end else begin
                        case (s_tuser)
                            OP_ENTER, OP_LOOKUP, OP_ZAP_KEY: begin
                                if (in_len_long) begin
                                    status_next = STAT_TOO_LONG;
                                    fsm_next    = FSM_DONE;
                                end else begin
                                    fsm_next = FSM_SCAN;
                                end
                            end
                            OP_ZAP_PARENT, OP_ZAP_CHILD, OP_FLUSH: fsm_next = FSM_SCAN;
                            default: fsm_next = FSM_DONE;
                        endcase
                    end
                end
            end
            FSM_SCAN: begin
                ctl.op       = CELL_SHIFT;
                found_next   = hit_now;
                removed_next = removed_now;
                if (probe_res.key_hit && op_reg == OP_LOOKUP) begin
                    found_child_next = cell_q[CACHE_ENTRIES-1].child;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    cnt_next = '0;
                    case (op_reg)
                        OP_ENTER: begin
                            if (hit_now) begin
                                status_next = STAT_DUPLICATE;
                                fsm_next    = FSM_DONE;
                            end else begin
                                fsm_next = FSM_INSERT;
                            end
                        end
                        OP_LOOKUP: begin
                            if (hit_now) begin
                                fsm_next = FSM_SORT;
                            end else begin
                                status_next = STAT_MISS;
                                fsm_next    = FSM_DONE;
                            end
                        end
                        OP_ZAP_PARENT, OP_ZAP_CHILD, OP_ZAP_KEY: begin
                            fsm_next = (removed_now != '0) ? FSM_SORT : FSM_DONE;
                        end
                        default: fsm_next = FSM_DONE;
                    endcase
                end
            end
            FSM_SORT: begin
                ctl.op   = CELL_SORT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    cnt_next = '0;
                    fsm_next = FSM_DONE;
                end
            end
            FSM_INSERT: begin
                // the last cell drops out of the row as the new entry comes in
                ctl.op       = CELL_SHIFT;
                evicted_next = cell_q[CACHE_ENTRIES-1].valid;
                removed_next = COUNT_W'(cell_q[CACHE_ENTRIES-1].valid);
                fsm_next     = FSM_DONE;
            end
            FSM_DONE: begin
                // a promoted hit has reached cell 0; drop its flag
                ctl.op = CELL_CLRHIT;
                if (out_free) begin
                    fsm_next = FSM_IDLE;
                end
            end
            default: fsm_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= FSM_IDLE;
            cnt_reg      <= '0;
            enable_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
            removed_reg  <= '0;
            evicted_reg  <= 1'b0;
            status_reg   <= STAT_OK;
        end else begin
            fsm_reg     <= fsm_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            removed_reg <= removed_next;
            evicted_reg <= evicted_next;
            status_reg  <= status_next;
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_data;
            end
            if (fsm_reg == FSM_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        found_child_reg <= found_child_next;
        if (s_accept) begin
            op_reg     <= s_tuser;
            parent_reg <= s_tdata[31:0];
            child_reg  <= s_tdata[63:32];
            target_reg <= s_tdata[95:64];
            lo_reg     <= s_tdata[159:96] & mask_low(in_len);
            hi_reg     <= s_tdata[223:160] & mask_high(in_len);
            len_reg    <= in_len[LEN_W-1:0];
        end
        if (fsm_reg == FSM_DONE && out_free) begin
            m_tdata_reg <= {6'b0, evicted_reg, removed_reg, found_child_reg};
            m_tuser_reg <= status_reg;
        end
    end

    // a request is taken only from idle, so the next cycle refuses another
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while busy");

    // an insert always closes the request
    a_insert_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fsm_reg == FSM_INSERT |=> fsm_reg == FSM_DONE)
        else $error("insert did not finish");

    // an eviction belongs to a successful enter and counts one removal
    a_evict_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[41] |-> m_tuser == STAT_OK && m_tdata[40:32] == 9'd1)
        else $error("eviction reported with wrong status or count");

    // a child handle is only returned with a hit status
    a_found_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[31:0] == 32'd0)
        else $error("child returned without a hit");

endmodule

>>> hw/rtl/hlc_cell.sv
// one cache entry cell of the recency ordered row
// depends on hlc_pkg; shifts, sorts with its neighbours, clears its hit flag or holds
module hlc_cell
    import hlc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  logic      cell_odd,
    input  entry_t    shift_in,
    input  entry_t    prev_in,
    input  entry_t    next_in,
    output entry_t    q
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t upper;
    entry_t lower;
    logic   is_upper;
    logic   swap;

    // odd-even transposition: pairs start at cells whose parity equals the phase
    always_comb begin
        is_upper = (cell_odd == ctl.phase);
        upper    = is_upper ? entry_reg : prev_in;
        lower    = is_upper ? next_in   : entry_reg;
        swap     = ctl.promote ? lower.hit : (!upper.valid && lower.valid);
        case (ctl.op)
            CELL_HOLD:   entry_next = entry_reg;
            CELL_SHIFT:  entry_next = shift_in;
            CELL_SORT:   entry_next = swap ? (is_upper ? next_in : prev_in) : entry_reg;
            CELL_CLRHIT: begin
                entry_next     = entry_reg;
                entry_next.hit = 1'b0;
            end
            default:     entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            entry_reg.hit   <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

>>> hw/rtl/hlc_probe.sv
// match and update logic for the entry leaving the end of the row
// depends on hlc_pkg; purely combinational
module hlc_probe
    import hlc_pkg::*;
(
    input  logic [2:0]          op,
    input  logic [HANDLE_W-1:0] key_parent,
    input  logic [NAME_W-1:0]   key_lo,
    input  logic [NAME_W-1:0]   key_hi,
    input  logic [LEN_W-1:0]    key_len,
    input  logic [HANDLE_W-1:0] target,
    input  entry_t              exit_entry,
    output entry_t              feed,
    output probe_t              res
);

    logic key_eq;
    logic handle_eq;

    always_comb begin
        key_eq = exit_entry.valid && exit_entry.len == key_len
                 && exit_entry.parent == key_parent
                 && exit_entry.name_lo == key_lo && exit_entry.name_hi == key_hi;
        handle_eq = 1'b0;
        feed      = exit_entry;
        res       = '0;
        case (op)
            OP_ENTER: res.key_hit = key_eq;
            OP_LOOKUP: begin
                res.key_hit = key_eq;
                feed.hit    = key_eq;
            end
            OP_ZAP_KEY: begin
                res.removed = key_eq;
                feed.valid  = exit_entry.valid && !key_eq;
            end
            OP_ZAP_PARENT, OP_ZAP_CHILD: begin
                handle_eq   = exit_entry.valid && ((op == OP_ZAP_PARENT)
                              ? exit_entry.parent == target : exit_entry.child == target);
                res.removed = handle_eq;
                feed.valid  = exit_entry.valid && !handle_eq;
            end
            OP_FLUSH: begin
                res.removed = exit_entry.valid;
                feed.valid  = 1'b0;
            end
            default: feed = exit_entry;
        endcase
    end

endmodule

>>> dv/name_cache_checker.sv
// result checker for the hashed lru name cache core: predicts every result from the
// accepted requests and compares it with what the result channel hands out
// depends on hlc_pkg
`timescale 1ns / 100ps

module name_cache_checker
    import hlc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [231:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    output int           mismatches,
    output int           outstanding
);

    typedef struct {
        logic [31:0] parent;
        logic [31:0] child;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  len;
    } cached_name_t;

    typedef struct {
        status_t     status;
        logic [31:0] found;
        logic [8:0]  removed;
        logic        evicted;
    } cache_reply_t;

    // valid entries only, most recent first; invalid ones always sit behind them
    cached_name_t recency[$];
    cache_reply_t replies_due[$];
    logic         enabled;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        enabled     = 1'b0;
    end

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch on %s: expected %0h, got %0h at %0t", field, want, got, $realtime);
        end
    endtask

    function automatic logic [127:0] kept_bytes(input logic [7:0] len);
        logic [127:0] m;
        m = '0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (len > k) m[8*k +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic int find_name(input cached_name_t key);
        for (int i = 0; i < recency.size(); i++) begin
            if (recency[i].parent == key.parent && recency[i].len == key.len &&
                recency[i].lo == key.lo && recency[i].hi == key.hi) return i;
        end
        return -1;
    endfunction

    function automatic cache_reply_t apply_request(input logic [2:0] op, input logic [231:0] d);
        cache_reply_t r;
        cached_name_t key;
        logic [127:0] m;
        logic [31:0]  target;
        int           hit;
        r = '{STAT_OK, '0, '0, 1'b0};
        key.parent = d[31:0];
        key.child  = d[63:32];
        target     = d[95:64];
        key.len    = d[231:224];
        m          = kept_bytes(key.len);
        key.lo     = d[159:96] & m[63:0];
        key.hi     = d[223:160] & m[127:64];
        if (!enabled) begin
            r.status = STAT_DISABLED;
            return r;
        end
        case (op)
            OP_ENTER, OP_LOOKUP, OP_ZAP_KEY: begin
                if (key.len > NAME_BYTES) begin
                    r.status = STAT_TOO_LONG;
                    return r;
                end
                hit = find_name(key);
                if (op == OP_ENTER) begin
                    if (hit >= 0) begin
                        r.status = STAT_DUPLICATE;
                    end else begin
                        if (recency.size() == CACHE_ENTRIES) begin
                            void'(recency.pop_back());
                            r.evicted = 1'b1;
                            r.removed = 9'd1;
                        end
                        recency.push_front(key);
                    end
                end else if (op == OP_LOOKUP) begin
                    if (hit < 0) begin
                        r.status = STAT_MISS;
                    end else begin
                        key     = recency[hit];
                        r.found = key.child;
                        recency.delete(hit);
                        recency.push_front(key);
                    end
                end else if (hit >= 0) begin
                    recency.delete(hit);
                    r.removed = 9'd1;
                end
            end
            OP_ZAP_PARENT, OP_ZAP_CHILD: begin
                for (int i = recency.size() - 1; i >= 0; i--) begin
                    if ((op == OP_ZAP_PARENT ? recency[i].parent : recency[i].child) == target) begin
                        recency.delete(i);
                        r.removed++;
                    end
                end
            end
            OP_FLUSH: begin
                r.removed = 9'(recency.size());
                recency.delete();
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        cache_reply_t want;
        if (!aresetn) begin
            enabled = 1'b0;
            recency.delete();
            replies_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) enabled = cfg_data;
            if (s_tvalid && s_tready) replies_due.push_back(apply_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    report("unrequested result", 64'd0, 64'({m_tuser, m_tdata}));
                end else begin
                    want = replies_due.pop_front();
                    if (m_tuser != want.status)
                        report("status", 64'(want.status), 64'(m_tuser));
                    if (m_tdata[31:0] != want.found)
                        report("found_child", 64'(want.found), 64'(m_tdata[31:0]));
                    if (m_tdata[40:32] != want.removed)
                        report("removed_count", 64'(want.removed), 64'(m_tdata[40:32]));
                    if (m_tdata[41] != want.evicted)
                        report("evicted_valid", 64'(want.evicted), 64'(m_tdata[41]));
                    if (m_tdata[47:42] != '0) report("padding", 64'd0, 64'(m_tdata[47:42]));
                end
            end
        end
        outstanding = replies_due.size();
    end

endmodule

>>> dv/hashed_lru_name_cache_core_test.sv
// testbench top for the hashed lru name cache core: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict
// depends on hlc_pkg, hashed_lru_name_cache_core and name_cache_checker
`timescale 1ns / 100ps

module hashed_lru_name_cache_core_test;
    import hlc_pkg::*;

    // opcodes the block does not define; it must answer them without touching the cache
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    // a scan plus a sort is the longest request; the limit allows many times its length
    localparam int STALL_LIMIT = 6000;

    typedef struct {
        logic [31:0] parent;
        logic [31:0] child;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  len;
    } name_key_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data  = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [231:0] s_tdata   = '0;
    logic [2:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [47:0]  m_tdata;
    logic [2:0]   m_tuser;

    int          mismatches;
    int          outstanding;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          stall_tick = 0;
    int          stall_mode = 0;
    name_key_t   recent_keys[$];
    logic [31:0] parents[12];
    logic [31:0] children[12];

    always #2 aclk = ~aclk;

    hashed_lru_name_cache_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    name_cache_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side back-pressure, in one of three patterns drawn at random:
    // mode 0 never stalls, mode 1 stalls half the time, mode 2 mostly stalls
    always @(posedge aclk) begin
        stall_tick++;
        if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog: ends the run when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // byte mask for the bytes of a name that lie below its length
    function automatic logic [127:0] name_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '0;
        for (int k = 0; k < 16; k++) begin
            if (len > k) m[8*k +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // one request; the sender works in bursts with random gaps between them
    task automatic issue(input logic [2:0] op, input name_key_t k, input logic [31:0] target);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {k.len, k.hi, k.lo, target, k.child, k.parent};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_enable(input logic on);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic name_key_t fresh_key();
        name_key_t k;
        int        r;
        k.parent = ($urandom_range(0, 3) != 0) ? parents[$urandom_range(0, 11)] : $urandom;
        k.child  = ($urandom_range(0, 3) != 0) ? children[$urandom_range(0, 11)] : $urandom;
        k.lo     = {$urandom, $urandom};
        k.hi     = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 3)      k.len = 8'd0;
        else if (r < 7) k.len = 8'($urandom_range(17, 255));
        else            k.len = 8'($urandom_range(1, NAME_BYTES));
        return k;
    endfunction

    // a key seen before, with fresh junk in the bytes beyond its length
    function automatic name_key_t known_key();
        name_key_t    k;
        logic [127:0] m;
        if (recent_keys.size() == 0) return fresh_key();
        k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        m = name_mask(k.len);
        {k.hi, k.lo} = ({k.hi, k.lo} & m) |
                       ({$urandom, $urandom, $urandom, $urandom} & ~m);
        return k;
    endfunction

    task automatic enter_key(input name_key_t k);
        if (k.len <= NAME_BYTES) begin
            recent_keys.push_back(k);
            if (recent_keys.size() > 96) void'(recent_keys.pop_front());
        end
        issue(OP_ENTER, k, $urandom);
    endtask

    // one random request; fill segments mostly enter so the cache reaches full and evicts
    task automatic random_request(input bit fill);
        name_key_t k;
        int        r;
        r = $urandom_range(0, 99);
        if (fill) begin
            if (r < 70) begin
                k = ($urandom_range(0, 6) == 0) ? known_key() : fresh_key();
                enter_key(k);
            end else begin
                issue(OP_LOOKUP, ($urandom_range(0, 4) != 0) ? known_key() : fresh_key(), $urandom);
            end
        end else if (r < 35) begin
            enter_key(fresh_key());
        end else if (r < 65) begin
            issue(OP_LOOKUP, ($urandom_range(0, 4) != 0) ? known_key() : fresh_key(), $urandom);
        end else if (r < 75) begin
            issue(OP_ZAP_KEY, known_key(), $urandom);
        end else if (r < 83) begin
            issue(OP_ZAP_PARENT, fresh_key(),
                  ($urandom_range(0, 4) != 0) ? parents[$urandom_range(0, 11)] : $urandom);
        end else if (r < 91) begin
            issue(OP_ZAP_CHILD, fresh_key(),
                  ($urandom_range(0, 4) != 0) ? children[$urandom_range(0, 11)] : $urandom);
        end else if (r < 93) begin
            issue(OP_FLUSH, fresh_key(), $urandom);
        end else if (r < 96) begin
            issue($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, fresh_key(), $urandom);
        end else begin
            enter_key(known_key());
        end
    endtask

    initial begin
        name_key_t k_short;
        name_key_t k_full;
        name_key_t k_empty;
        name_key_t k_long;
        for (int i = 0; i < 12; i++) begin
            parents[i]  = $urandom;
            children[i] = $urandom;
        end
        parents[0]  = '0;
        parents[1]  = '1;
        children[0] = '0;
        children[1] = '1;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        k_short = '{32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF41, '1, 8'd1};
        k_full  = '{32'hFFFF_FFFF, 32'h0, '1, '1, 8'd16};
        k_empty = '{32'h5, 32'h1234_5678, 64'h0, 64'h0, 8'd0};
        k_long  = '{32'h7, 32'h9, '1, '1, 8'd255};

        // cache left disabled after reset: everything reports disabled
        issue(OP_ENTER, k_short, '0);
        issue(OP_FLUSH, k_long, '1);
        issue(OP_SPARE_HI, k_long, '1);

        write_enable(1'b1);
        // directed requests: duplicates, hits, misses, name length extremes
        issue(OP_ENTER, k_short, '0);
        issue(OP_ENTER, k_short, '0);
        issue(OP_LOOKUP, k_short, '0);
        issue(OP_LOOKUP, k_full, '0);
        issue(OP_ENTER, k_full, '0);
        issue(OP_LOOKUP, k_full, '0);
        issue(OP_ENTER, k_empty, '0);
        k_empty.lo = '1;
        k_empty.hi = '1;
        issue(OP_LOOKUP, k_empty, '0);
        k_long.len = 8'd17;
        issue(OP_LOOKUP, k_long, '0);
        k_long.len = 8'd255;
        issue(OP_ENTER, k_long, '0);
        k_long.len = 8'd200;
        issue(OP_ZAP_KEY, k_long, '0);
        issue(OP_ZAP_PARENT, k_long, 32'h5);
        issue(OP_ZAP_CHILD, k_long, 32'hFFFF_FFFF);
        issue(OP_ZAP_KEY, k_short, '0);
        issue(OP_ZAP_KEY, k_full, '0);
        issue(OP_SPARE_LO, k_long, '0);
        issue(OP_SPARE_HI, k_long, '0);
        issue(OP_ENTER, k_short, '0);
        issue(OP_FLUSH, k_long, '0);
        issue(OP_LOOKUP, k_short, '0);

        // random part in segments, alternating fill and mixed traffic
        for (int seg = 0; seg < 8; seg++) begin
            for (int i = 0; i < 200; i++) random_request(seg % 2 == 0);
            if (seg == 3) begin
                write_enable(1'b0);
                for (int i = 0; i < 12; i++) random_request(1'b0);
                write_enable(1'b1);
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/hlc_pkg.sv
hw/rtl/hlc_cell.sv
hw/rtl/hlc_probe.sv
hw/rtl/hashed_lru_name_cache_core.sv
dv/name_cache_checker.sv
dv/hashed_lru_name_cache_core_test.sv
